/* hdl/pidc_pkg.sv */
`default_nettype none
package pidc_pkg;

  // interval above this clears the controller, unsigned Q8.16 seconds
  localparam int unsigned TIMEOUT_TIME = 65536;
  // period of the error wrap, zero turns wrapping off
  localparam int unsigned WRAP_SPAN    = 0;
  localparam int unsigned WRAP_HALF    = WRAP_SPAN / 2;

  localparam logic [2:0] REG_MODE      = 3'd0;
  localparam logic [2:0] REG_GAIN_P    = 3'd1;
  localparam logic [2:0] REG_GAIN_I    = 3'd2;
  localparam logic [2:0] REG_GAIN_D    = 3'd3;
  localparam logic [2:0] REG_GAIN_BACK = 3'd4;
  localparam logic [2:0] REG_FILTER    = 3'd5;
  localparam logic [2:0] REG_INT_LIM   = 3'd6;
  localparam logic [2:0] REG_OUT_LIM   = 3'd7;

  localparam logic [2:0] MODE_POS_CLAMP = 3'd1;
  localparam logic [2:0] MODE_POS_BACK  = 3'd2;
  localparam logic [2:0] MODE_INC_PLAIN = 3'd3;
  localparam logic [2:0] MODE_INC_BACK  = 3'd5;

  typedef struct packed {
    logic signed [31:0] setpoint;
    logic signed [31:0] measurement;
    logic [23:0]        elapsed;
  } pidc_in_t;

  typedef struct packed {
    logic signed [31:0] drive;
    logic               was_cleared;
  } pidc_out_t;

  function automatic logic signed [35:0] ext36(input logic signed [31:0] v);
    return {{4{v[31]}}, v};
  endfunction

  function automatic logic signed [31:0] sat36(input logic signed [35:0] v);
    if (v > 36'sh0_7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (v < 36'shF_8000_0000) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] clamp_sym(input logic signed [31:0] v,
                                                   input logic [30:0] lim);
    logic signed [35:0] l;
    l = {5'b0, lim};
    if (ext36(v) > l) return {1'b0, lim};
    if (ext36(v) < -l) return -$signed({1'b0, lim});
    return v;
  endfunction

  // floor of (a + b) / 2
  function automatic logic signed [31:0] half_sum(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
    logic signed [32:0] s;
    s = {a[31], a} + {b[31], b};
    return s[32:1];
  endfunction

endpackage
`default_nettype wire

/* hdl/pid_controller_step_unit.sv */
`default_nettype none
// channel   direction  handshake             payload
// in_       input      in_valid / in_stall   pidc_in_t  setpoint, measurement, elapsed
// out_      output     out_valid / out_stall pidc_out_t drive, was_cleared
// cfg_      input      cfg_we                cfg_index selects register, cfg_wdata
//
// one transaction at a time through a bit-serial multiplier and a bit-serial
// divider; a step that clears on its interval skips the products (with
// back-calculation it still needs one), and otherwise the number of serial
// products is set by the mode and the filter setting.
// synchronous reset restores configuration and controller state, not step operands.
// the finished result sits in an output register, so a new transaction is
// taken while out_stall holds the previous one.
module pid_controller_step_unit import pidc_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire pidc_in_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output pidc_out_t      out_data,
  input  wire logic      cfg_we,
  input  wire logic [2:0] cfg_index,
  input  wire logic [31:0] cfg_wdata
);

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_ERR  = 5'd1;
  localparam logic [4:0] S_WRAP = 5'd2;
  localparam logic [4:0] S_HIST = 5'd3;
  localparam logic [4:0] S_BC   = 5'd4;
  localparam logic [4:0] S_CHK  = 5'd5;
  localparam logic [4:0] S_PP   = 5'd6;
  localparam logic [4:0] S_PI1  = 5'd7;
  localparam logic [4:0] S_PI2  = 5'd8;
  localparam logic [4:0] S_F1   = 5'd9;
  localparam logic [4:0] S_F2   = 5'd10;
  localparam logic [4:0] S_F3   = 5'd11;
  localparam logic [4:0] S_PR1  = 5'd12;
  localparam logic [4:0] S_PRD  = 5'd13;
  localparam logic [4:0] S_PSUM = 5'd14;
  localparam logic [4:0] S_IP   = 5'd15;
  localparam logic [4:0] S_II   = 5'd16;
  localparam logic [4:0] S_ID0  = 5'd17;
  localparam logic [4:0] S_ISUM = 5'd18;
  localparam logic [4:0] S_OUT  = 5'd19;

  // configuration
  logic [2:0]         mode_r;
  logic signed [31:0] gain_p_r, gain_i_r, gain_d_r, gain_back_r;
  logic [30:0]        filter_r, int_lim_r, out_lim_r;

  // controller state
  logic signed [31:0] eh0_r, eh1_r, eh2_r;
  logic signed [31:0] ih0_r, ih1_r;
  logic signed [31:0] dh0_r, dh1_r;
  logic signed [31:0] integ_r, dint_r, oc_r, orw_r;

  // step working registers
  logic [4:0]         state_r;
  logic               wait_r;
  logic signed [31:0] sp_r, ms_r;
  logic [23:0]        dt_r;
  logic signed [32:0] e_r;
  logic               wrap_neg_r;
  logic signed [31:0] p_r, t_r, sum_r;
  logic signed [31:0] res_drive_r;
  logic               res_clr_r;
  logic               out_valid_r;
  pidc_out_t          out_data_r;

  logic               mul_go_r;
  logic signed [31:0] mul_a_r, mul_b_r;
  logic               mul_done;
  logic signed [31:0] mul_res;
  logic               div_go_r;
  logic [47:0]        div_n_r;
  logic [31:0]        div_d_r;
  logic               div_done;
  logic [47:0]        div_quo;
  logic [31:0]        div_rem;

  logic               form_inc;
  logic signed [31:0] dt32, fc32;
  logic signed [33:0] wrap_x;
  logic [33:0]        wrap_abs;
  logic [31:0]        wrap_m;
  logic               orw_big;
  logic               skip_int;
  logic signed [31:0] f1_arg;
  logic signed [31:0] d2_arg;
  logic signed [31:0] sum_now;
  logic [31:0]        q_abs;
  logic signed [31:0] quo_sat;

  pidc_mul u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mul_go_r),
    .op_a   (mul_a_r),
    .op_b   (mul_b_r),
    .done   (mul_done),
    .result (mul_res)
  );

  pidc_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_go_r),
    .dividend  (div_n_r),
    .divisor   (div_d_r),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  always_comb begin
    form_inc = (mode_r >= MODE_INC_PLAIN);
    dt32     = {8'b0, dt_r};
    fc32     = {1'b0, filter_r};
    wrap_x   = {e_r[32], e_r} + 34'(WRAP_HALF);
    wrap_abs = wrap_x[33] ? 34'(-wrap_x) : wrap_x;
    wrap_m   = (wrap_neg_r && div_rem != 32'd0) ? 32'(WRAP_SPAN) - div_rem : div_rem;
    orw_big  = (ext36(orw_r) > $signed({5'b0, out_lim_r}))
            || (ext36(orw_r) < -$signed({5'b0, out_lim_r}));
    // conditional integration holds the integral while pushing further into saturation
    skip_int = (mode_r == MODE_POS_CLAMP) && orw_big && (gain_i_r != 32'sd0)
            && (eh0_r != 32'sd0) && (orw_r[31] == (gain_i_r[31] ^ eh0_r[31]));
    f1_arg   = form_inc ? sat36(ext36(eh0_r) - ext36(eh1_r) - ext36(dint_r))
                        : sat36(ext36(eh0_r) - ext36(dint_r));
    d2_arg   = sat36(ext36(eh0_r) - (ext36(eh1_r) <<< 1) + ext36(eh2_r));
    sum_now  = sat36(ext36(p_r) + ext36(integ_r) + ext36(dh0_r));
    q_abs    = t_r[31] ? 32'(-t_r) : t_r;
    if (!wrap_neg_r) begin
      quo_sat = (div_quo > 48'h0000_7FFF_FFFF) ? 32'sh7FFF_FFFF : div_quo[31:0];
    end else begin
      quo_sat = (div_quo > 48'h0000_8000_0000) ? 32'sh8000_0000 : -div_quo[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= '0;
      gain_p_r    <= '0;
      gain_i_r    <= '0;
      gain_d_r    <= '0;
      gain_back_r <= '0;
      filter_r    <= '0;
      int_lim_r   <= 31'h7FFF_FFFF;
      out_lim_r   <= 31'h7FFF_FFFF;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MODE:      mode_r      <= cfg_wdata[2:0];
        REG_GAIN_P:    gain_p_r    <= cfg_wdata;
        REG_GAIN_I:    gain_i_r    <= cfg_wdata;
        REG_GAIN_D:    gain_d_r    <= cfg_wdata;
        REG_GAIN_BACK: gain_back_r <= cfg_wdata;
        REG_FILTER:    filter_r    <= cfg_wdata[30:0];
        REG_INT_LIM:   int_lim_r   <= cfg_wdata[30:0];
        REG_OUT_LIM:   out_lim_r   <= cfg_wdata[30:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    mul_go_r <= 1'b0;
    div_go_r <= 1'b0;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wait_r      <= 1'b0;
      out_valid_r <= 1'b0;
      eh0_r <= '0; eh1_r <= '0; eh2_r <= '0;
      ih0_r <= '0; ih1_r <= '0;
      dh0_r <= '0; dh1_r <= '0;
      integ_r <= '0; dint_r <= '0; oc_r <= '0; orw_r <= '0;
    end else begin
      if (out_valid_r && !out_stall && state_r != S_OUT) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            sp_r    <= in_data.setpoint;
            ms_r    <= in_data.measurement;
            dt_r    <= in_data.elapsed;
            state_r <= S_ERR;
          end
        end
        S_ERR: begin
          e_r     <= {sp_r[31], sp_r} - {ms_r[31], ms_r};
          state_r <= (WRAP_SPAN > 0) ? S_WRAP : S_HIST;
        end
        S_WRAP: begin
          if (!wait_r) begin
            div_go_r   <= 1'b1;
            div_n_r    <= {14'b0, wrap_abs};
            div_d_r    <= 32'(WRAP_SPAN);
            wrap_neg_r <= wrap_x[33];
            wait_r     <= 1'b1;
          end else if (div_done) begin
            e_r     <= $signed({1'b0, wrap_m}) - 33'(WRAP_HALF);
            wait_r  <= 1'b0;
            state_r <= S_HIST;
          end
        end
        S_HIST: begin
          eh2_r <= eh1_r;
          eh1_r <= eh0_r;
          eh0_r <= sat36({{3{e_r[32]}}, e_r});
          if (mode_r == MODE_POS_BACK || mode_r == MODE_INC_BACK) begin
            state_r <= S_BC;
          end else begin
            ih1_r   <= ih0_r;
            ih0_r   <= sat36({{3{e_r[32]}}, e_r});
            state_r <= S_CHK;
          end
        end
        S_BC: begin
          if (!wait_r) begin
            mul_go_r <= 1'b1;
            mul_a_r  <= gain_back_r;
            mul_b_r  <= sat36(ext36(oc_r) - ext36(orw_r));
            wait_r   <= 1'b1;
          end else if (mul_done) begin
            ih1_r   <= ih0_r;
            ih0_r   <= sat36(ext36(mul_res) + ext36(eh0_r));
            wait_r  <= 1'b0;
            state_r <= S_CHK;
          end
        end
        S_CHK: begin
          if (dt_r == 24'd0 || dt_r > 24'(TIMEOUT_TIME)) begin
            eh0_r <= '0; eh1_r <= '0; eh2_r <= '0;
            ih0_r <= '0; ih1_r <= '0;
            dh0_r <= '0; dh1_r <= '0;
            integ_r <= '0; dint_r <= '0; oc_r <= '0; orw_r <= '0;
            res_drive_r <= '0;
            res_clr_r   <= 1'b1;
            state_r     <= S_OUT;
          end else begin
            state_r <= form_inc ? S_IP : S_PP;
          end
        end
        S_PP: begin
          if (!wait_r) begin
            mul_go_r <= 1'b1;
            mul_a_r  <= gain_p_r;
            mul_b_r  <= eh0_r;
            wait_r   <= 1'b1;
          end else if (mul_done) begin
            p_r    <= mul_res;
            wait_r <= 1'b0;
            if (!skip_int) state_r <= S_PI1;
            else state_r <= (filter_r != 31'd0) ? S_F1 : S_PR1;
          end
        end
        S_PI1: begin
          if (!wait_r) begin
            mul_go_r <= 1'b1;
            mul_a_r  <= gain_i_r;
            mul_b_r  <= half_sum(ih0_r, ih1_r);
            wait_r   <= 1'b1;
          end else if (mul_done) begin
            t_r     <= mul_res;
            wait_r  <= 1'b0;
            state_r <= S_PI2;
          end
        end
        S_PI2: begin
          if (!wait_r) begin
            mul_go_r <= 1'b1;
            mul_a_r  <= t_r;
            mul_b_r  <= dt32;
            wait_r   <= 1'b1;
          end else if (mul_done) begin
            integ_r <= clamp_sym(sat36(ext36(integ_r) + ext36(mul_res)), int_lim_r);
            wait_r  <= 1'b0;
            state_r <= (filter_r != 31'd0) ? S_F1 : S_PR1;
          end
        end
        // filtered derivative, shared by both forms
        S_F1: begin
          if (!wait_r) begin
            mul_go_r <= 1'b1;
            mul_a_r  <= fc32;
            mul_b_r  <= f1_arg;
            wait_r   <= 1'b1;
          end else if (mul_done) begin
            t_r     <= mul_res;
            wait_r  <= 1'b0;
            state_r <= S_F2;
          end
        end
        S_F2: begin
          if (!wait_r) begin
            mul_go_r <= 1'b1;
            mul_a_r  <= gain_d_r;
            mul_b_r  <= t_r;
            wait_r   <= 1'b1;
          end else if (mul_done) begin
            dh1_r   <= dh0_r;
            dh0_r   <= mul_res;
            wait_r  <= 1'b0;
            state_r <= S_F3;
          end
        end
        S_F3: begin
          if (!wait_r) begin
            mul_go_r <= 1'b1;
            mul_a_r  <= dt32;
            mul_b_r  <= half_sum(dh0_r, dh1_r);
            wait_r   <= 1'b1;
          end else if (mul_done) begin
            dint_r  <= sat36(ext36(dint_r) + ext36(mul_res));
            wait_r  <= 1'b0;
            state_r <= form_inc ? S_ISUM : S_PSUM;
          end
        end
        S_PR1: begin
          if (!wait_r) begin
            mul_go_r <= 1'b1;
            mul_a_r  <= gain_d_r;
            mul_b_r  <= sat36(ext36(eh0_r) - ext36(eh1_r));
            wait_r   <= 1'b1;
          end else if (mul_done) begin
            t_r     <= mul_res;
            wait_r  <= 1'b0;
            state_r <= S_PRD;
          end
        end
        // raw difference over the interval, truncated toward zero
        S_PRD: begin
          if (!wait_r) begin
            div_go_r   <= 1'b1;
            div_n_r    <= {q_abs, 16'b0};
            div_d_r    <= {8'b0, dt_r};
            wrap_neg_r <= t_r[31];
            wait_r     <= 1'b1;
          end else if (div_done) begin
            dh0_r   <= quo_sat;
            wait_r  <= 1'b0;
            state_r <= S_PSUM;
          end
        end
        S_PSUM: begin
          orw_r       <= sum_now;
          oc_r        <= clamp_sym(sum_now, out_lim_r);
          res_drive_r <= clamp_sym(sum_now, out_lim_r);
          res_clr_r   <= 1'b0;
          state_r     <= S_OUT;
        end
        S_IP: begin
          if (!wait_r) begin
            mul_go_r <= 1'b1;
            mul_a_r  <= gain_p_r;
            mul_b_r  <= sat36(ext36(eh0_r) - ext36(eh1_r));
            wait_r   <= 1'b1;
          end else if (mul_done) begin
            p_r     <= mul_res;
            wait_r  <= 1'b0;
            state_r <= S_II;
          end
        end
        S_II: begin
          if (!wait_r) begin
            mul_go_r <= 1'b1;
            mul_a_r  <= gain_i_r;
            mul_b_r  <= eh0_r;
            wait_r   <= 1'b1;
          end else if (mul_done) begin
            integ_r <= clamp_sym(mul_res, int_lim_r);
            wait_r  <= 1'b0;
            state_r <= (filter_r != 31'd0) ? S_F1 : S_ID0;
          end
        end
        S_ID0: begin
          if (!wait_r) begin
            mul_go_r <= 1'b1;
            mul_a_r  <= gain_d_r;
            mul_b_r  <= d2_arg;
            wait_r   <= 1'b1;
          end else if (mul_done) begin
            dh0_r   <= mul_res;
            wait_r  <= 1'b0;
            state_r <= S_ISUM;
          end
        end
        // incremental output integrates the trapezoid of the raw outputs
        S_ISUM: begin
          if (!wait_r) begin
            sum_r    <= sum_now;
            mul_go_r <= 1'b1;
            mul_a_r  <= dt32;
            mul_b_r  <= half_sum(orw_r, sum_now);
            wait_r   <= 1'b1;
          end else if (mul_done) begin
            oc_r        <= clamp_sym(sat36(ext36(oc_r) + ext36(mul_res)), out_lim_r);
            res_drive_r <= clamp_sym(sat36(ext36(oc_r) + ext36(mul_res)), out_lim_r);
            res_clr_r   <= 1'b0;
            orw_r       <= sum_r;
            wait_r      <= 1'b0;
            state_r     <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r            <= 1'b1;
            out_data_r.drive       <= res_drive_r;
            out_data_r.was_cleared <= res_clr_r;
            state_r                <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

/* hdl/pidc_mul.sv */
`default_nettype none
module pidc_mul import pidc_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic signed [31:0] op_a,
  input  wire logic signed [31:0] op_b,
  output logic                    done,
  output logic signed [31:0]      result
);

  logic               busy_r;
  logic               rnd_r;
  logic [4:0]         cnt_r;
  logic signed [31:0] a_r;
  logic [31:0]        b_r;
  logic signed [32:0] hi_r;
  logic [31:0]        lo_r;
  logic signed [31:0] res_r;
  logic               done_r;

  logic signed [33:0] addend;
  logic signed [33:0] sum;
  logic signed [64:0] rnd;
  logic signed [48:0] shifted;

  always_comb begin
    addend = {{2{a_r[31]}}, a_r};
    // top multiplier bit carries negative weight
    if (cnt_r == 5'd31) addend = -addend;
    if (!b_r[0]) addend = '0;
    sum = {hi_r[32], hi_r} + addend;
    rnd = {hi_r, lo_r} + 65'sd32768;
    shifted = rnd[64:16];
  end

  always_ff @(posedge clk) begin
    done_r <= 1'b0;
    if (!rst_n) begin
      busy_r <= 1'b0;
      rnd_r  <= 1'b0;
    end else if (start && !busy_r) begin
      a_r    <= op_a;
      b_r    <= op_b;
      hi_r   <= '0;
      lo_r   <= '0;
      cnt_r  <= '0;
      busy_r <= 1'b1;
      rnd_r  <= 1'b0;
    end else if (busy_r && !rnd_r) begin
      hi_r  <= sum[33:1];
      lo_r  <= {sum[0], lo_r[31:1]};
      b_r   <= {1'b0, b_r[31:1]};
      cnt_r <= cnt_r + 5'd1;
      if (cnt_r == 5'd31) rnd_r <= 1'b1;
    end else if (busy_r) begin
      if (shifted > 49'sh0_0000_7FFF_FFFF) res_r <= 32'sh7FFF_FFFF;
      else if (shifted < 49'sh1_FFFF_8000_0000) res_r <= 32'sh8000_0000;
      else res_r <= shifted[31:0];
      done_r <= 1'b1;
      busy_r <= 1'b0;
      rnd_r  <= 1'b0;
    end
  end

  assign done   = done_r;
  assign result = res_r;

endmodule
`default_nettype wire

/* hdl/pidc_div.sv */
`default_nettype none
module pidc_div import pidc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [47:0] dividend,
  input  wire logic [31:0] divisor,
  output logic             done,
  output logic [47:0]      quotient,
  output logic [31:0]      remainder
);

  logic        busy_r;
  logic [5:0]  cnt_r;
  logic [31:0] rem_r;
  logic [47:0] quo_r;
  logic [31:0] dsr_r;
  logic        done_r;

  logic [33:0] trial;

  // restoring division, one quotient bit per cycle
  assign trial = {1'b0, rem_r, quo_r[47]} - {2'b0, dsr_r};

  always_ff @(posedge clk) begin
    done_r <= 1'b0;
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start && !busy_r) begin
      rem_r  <= '0;
      quo_r  <= dividend;
      dsr_r  <= divisor;
      cnt_r  <= '0;
      busy_r <= 1'b1;
    end else if (busy_r) begin
      if (!trial[33]) begin
        rem_r <= trial[31:0];
        quo_r <= {quo_r[46:0], 1'b1};
      end else begin
        rem_r <= {rem_r[30:0], quo_r[47]};
        quo_r <= {quo_r[46:0], 1'b0};
      end
      cnt_r <= cnt_r + 6'd1;
      if (cnt_r == 6'd47) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule
`default_nettype wire
